// ===== rtl/cfcp_pkg.sv =====
package cfcp_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 256;
  localparam int NUM_CODES = 8;
  localparam int CODE_IDX_W = $clog2(NUM_CODES);

  // sections
  localparam logic [3:0] SEC_SENDER   = 4'd0;
  localparam logic [3:0] SEC_RECEIVER = 4'd1;
  localparam logic [3:0] SEC_COMMAND  = 4'd2;
  localparam logic [3:0] SEC_COLON    = 4'd3;
  localparam logic [3:0] SEC_PARAM1   = 4'd4;
  localparam logic [3:0] SEC_PARAM6   = 4'd9;
  localparam logic [3:0] SEC_ERROR    = 4'd10;

  // per-character status
  localparam logic [2:0] ST_IGNORED   = 3'd0;
  localparam logic [2:0] ST_STORED    = 3'd1;
  localparam logic [2:0] ST_SEPARATOR = 3'd2;
  localparam logic [2:0] ST_COMMAND   = 3'd3;
  localparam logic [2:0] ST_ERROR     = 3'd4;
  localparam logic [2:0] ST_COMPLETE  = 3'd5;
  localparam logic [2:0] ST_REJECTED  = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] FOLD_MASK = 8'hDF;

  typedef logic [NUM_CODES-1:0][7:0] code_array_t;

  // R W S A C I L V, index 0 in the low byte
  localparam code_array_t CODE_RESET = {8'h56, 8'h4C, 8'h49, 8'h43,
                                        8'h41, 8'h53, 8'h57, 8'h52};

  typedef struct packed {
    logic [2:0]            status;
    logic [7:0]            stored_byte;
    logic [CODE_IDX_W-1:0] command_index;
    logic [3:0]            section_next;
    logic                  quote_next;
    logic                  fill_inc;
    logic                  restart;
  } step_t;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic is_param_char(input logic [7:0] c);
    logic hit;
    hit = (c >= "a" && c <= "z") || is_ident(c);
    case (c)
      "+", "-", "*", "/", ".", "<", ">", "=", "%", "$", " ", ",", "(", ")": hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? (c & FOLD_MASK) : c;
  endfunction

endpackage

// ===== rtl/cfcp_step.sv =====
module cfcp_step (
  input  logic [7:0]           ch,
  input  logic [3:0]           section,
  input  logic                 in_quote,
  input  logic                 full,
  input  cfcp_pkg::code_array_t codes,
  output cfcp_pkg::step_t      step
);
  import cfcp_pkg::*;

  logic                  cmd_hit;
  logic [CODE_IDX_W-1:0] cmd_idx;
  logic [7:0]            folded;
  logic [7:0]            pchar;
  logic                  line_end;

  // lowest matching index wins
  always_comb begin
    cmd_hit = 1'b0;
    cmd_idx = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (codes[i] == ch) begin
        cmd_hit = 1'b1;
        cmd_idx = CODE_IDX_W'(i);
      end
    end
  end

  assign folded   = fold(ch);
  assign pchar    = in_quote ? ch : folded;
  assign line_end = (ch == CH_CR) || (ch == CH_LF) || (ch == CH_NUL);

  always_comb begin
    step = '0;
    step.status       = ST_IGNORED;
    step.section_next = section;
    step.quote_next   = in_quote;

    if (full) begin
      step.status  = ST_OVERFLOW;
      step.restart = 1'b1;
    end else if (line_end) begin
      step.restart = 1'b1;
      if (section inside {[SEC_PARAM1:SEC_PARAM6]}) begin
        step.status = ST_COMPLETE;
      end else begin
        step.status = ST_REJECTED;
      end
    end else if (section > SEC_PARAM6) begin
      step.status = ST_IGNORED;
    end else if (ch == CH_COLON) begin
      if (section == SEC_COLON) begin
        step.section_next = SEC_PARAM1;
        step.status       = ST_SEPARATOR;
      end else begin
        step.section_next = SEC_ERROR;
        step.status       = ST_ERROR;
      end
    end else if (ch == CH_COMMA && !in_quote) begin
      if (section inside {SEC_COMMAND, SEC_COLON, SEC_PARAM6}) begin
        step.section_next = SEC_ERROR;
        step.status       = ST_ERROR;
      end else begin
        step.section_next = (section == SEC_RECEIVER) ? SEC_COMMAND : section + 4'd1;
        step.status       = ST_SEPARATOR;
        step.fill_inc     = 1'b1;
      end
    end else begin
      case (section)
        SEC_SENDER, SEC_RECEIVER: begin
          if (is_ident((section == SEC_RECEIVER) ? folded : ch)) begin
            step.status      = ST_STORED;
            step.stored_byte = (section == SEC_RECEIVER) ? folded : ch;
            step.fill_inc    = 1'b1;
          end else begin
            step.section_next = SEC_ERROR;
            step.status       = ST_ERROR;
          end
        end
        SEC_COMMAND: begin
          if (cmd_hit) begin
            step.section_next  = SEC_COLON;
            step.status        = ST_COMMAND;
            step.command_index = cmd_idx;
          end else begin
            step.section_next = SEC_ERROR;
            step.status       = ST_ERROR;
          end
        end
        SEC_COLON: begin
          step.status = ST_IGNORED;
        end
        default: begin
          if (ch == CH_QUOTE) begin
            step.quote_next  = !in_quote;
            step.status      = ST_STORED;
            step.stored_byte = ch;
            step.fill_inc    = 1'b1;
          end else if (is_param_char(pchar)) begin
            step.status      = ST_STORED;
            step.stored_byte = pchar;
            step.fill_inc    = 1'b1;
          end else begin
            step.section_next = SEC_ERROR;
            step.status       = ST_ERROR;
          end
        end
      endcase
    end

    if (step.restart) begin
      step.section_next = SEC_SENDER;
      step.quote_next   = 1'b0;
    end
  end

endmodule

// ===== rtl/command_frame_char_parser.sv =====
// Command frame character parser. Takes one received character per transfer on
// the input channel and returns exactly one result per character, telling what
// the parser did with it (stored, separator, command, ignored, error, complete,
// rejected, overflow) along with the section it was in, the byte and buffer
// position written and the quote flag afterwards. A new character can be taken
// every cycle unless out_stall holds the result. A character is held in the
// input register while the step logic works on it, and its result is loaded
// into the result register at the same edge that updates the section, fill
// count and quote state. The user must write the eight command codes through
// the cfg port only while the parser is idle; the block does not enforce this.
// cfg_ready is always high. The frame state returns to the sender section on
// its own after a frame completes, is rejected or overflows BUFFER_BYTES.
module command_frame_char_parser #(
  parameter int BUFFER_BYTES = cfcp_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_char,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfcp_pkg::CODE_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [3:0]                      section,
  output logic [7:0]                      stored_byte,
  output logic [7:0]                      position,
  output logic [cfcp_pkg::CODE_IDX_W-1:0] command_index,
  output logic                            quoted
);
  import cfcp_pkg::*;

  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

  code_array_t       codes;
  logic [3:0]        phase;
  logic [FILL_W-1:0] fill_count;
  logic              in_quote;

  logic              char_valid;
  logic [7:0]        char_reg;
  logic              out_free;
  logic              advance;
  logic              full;
  step_t             step;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = char_valid && out_free;
  assign in_stall  = char_valid && !out_free;
  assign full      = fill_count >= FILL_W'(BUFFER_BYTES);

  cfcp_step u_step (
    .ch       (char_reg),
    .section  (phase),
    .in_quote (in_quote),
    .full     (full),
    .codes    (codes),
    .step     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      codes      <= CODE_RESET;
      phase      <= SEC_SENDER;
      fill_count <= '0;
      in_quote   <= 1'b0;
      char_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        codes[cfg_index] <= cfg_data;
      end

      if (!in_stall) begin
        char_valid <= in_valid;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (advance) begin
        phase    <= step.section_next;
        in_quote <= step.quote_next;
        if (step.restart) begin
          fill_count <= '0;
        end else if (step.fill_inc) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_reg <= rx_char;
    end
    if (advance) begin
      status        <= step.status;
      section       <= phase;
      stored_byte   <= step.stored_byte;
      position      <= 8'(fill_count);
      command_index <= step.command_index;
      quoted        <= step.quote_next;
    end
  end

endmodule

// ===== verif/command_frame_char_parser_tb.sv =====
module command_frame_char_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfcp_pkg::*;

  localparam int BUF_BYTES = BUFFER_BYTES_DEFAULT;
  localparam string IDENT_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  localparam string LOWER_CHARS = "abcdefghijklmnopqrstuvwxyz";
  localparam string RECV_CHARS  = "ABCXYZabcmxyz0189_";
  localparam string PARAM_CHARS = "abcxyzAMZ09_+-*/.<>=%$ ()";
  localparam string QUOTED_CHARS = "abz AZ09,_+-()";

  typedef struct packed {
    logic [2:0]            status;
    logic [3:0]            section;
    logic [7:0]            stored_byte;
    logic [7:0]            position;
    logic [CODE_IDX_W-1:0] command_index;
    logic                  quoted;
  } char_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_char = 8'h00;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CODE_IDX_W-1:0] cfg_index = '0;
  logic [7:0]            cfg_data = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            status;
  logic [3:0]            section;
  logic [7:0]            stored_byte;
  logic [7:0]            position;
  logic [CODE_IDX_W-1:0] command_index;
  logic                  quoted;

  command_frame_char_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_char       (rx_char),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .section       (section),
    .stored_byte   (stored_byte),
    .position      (position),
    .command_index (command_index),
    .quoted        (quoted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser shadow state
  logic [7:0]   cmd_codes [NUM_CODES];
  logic [3:0]   sec_q = SEC_SENDER;
  logic [8:0]   fill_q = '0;
  logic         quote_q = 1'b0;

  logic [7:0]   rx_backlog [$];
  char_report_t char_reports_due [$];
  char_report_t want_report, got_report;
  logic [7:0]   line_ends [3] = '{CH_CR, CH_LF, CH_NUL};
  int           in_gap = 0;
  int           out_gap = 0;
  bit           idle_on = 1'b1;
  int           fail_count = 0;

  initial begin
    for (int i = 0; i < NUM_CODES; i++) cmd_codes[i] = CODE_RESET[i];
  end

  function automatic void frame_restart();
    sec_q = SEC_SENDER;
    fill_q = '0;
    quote_q = 1'b0;
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? {c[7:6], 1'b0, c[4:0]} : c;
  endfunction

  // Works out what the parser reports for one character and advances the shadow state.
  function automatic char_report_t classify_char(input logic [7:0] c);
    char_report_t r;
    logic [7:0]   f;
    logic         wr;
    logic         hit;
    logic         ok;
    r = '0;
    r.section = sec_q;
    r.position = fill_q[7:0];
    wr = 1'b0;
    hit = 1'b0;
    if (fill_q >= BUF_BYTES) begin
      r.status = ST_OVERFLOW;
      frame_restart();
    end else if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
      if (sec_q >= SEC_PARAM1 && sec_q <= SEC_PARAM6) begin
        r.status = ST_COMPLETE;
        wr = 1'b1;
      end else begin
        r.status = ST_REJECTED;
      end
      frame_restart();
    end else if (sec_q > SEC_PARAM6) begin
      r.status = ST_IGNORED;
    end else if (c == CH_COLON) begin
      if (sec_q == SEC_COLON) begin
        sec_q = SEC_PARAM1;
        r.status = ST_SEPARATOR;
      end else begin
        sec_q = SEC_ERROR;
        r.status = ST_ERROR;
      end
    end else if (c == CH_COMMA && !quote_q) begin
      if (sec_q == SEC_COMMAND || sec_q == SEC_COLON || sec_q == SEC_PARAM6) begin
        sec_q = SEC_ERROR;
        r.status = ST_ERROR;
      end else begin
        sec_q = (sec_q == SEC_RECEIVER) ? SEC_COMMAND : sec_q + 4'd1;
        r.status = ST_SEPARATOR;
        wr = 1'b1;
      end
    end else if (sec_q == SEC_SENDER || sec_q == SEC_RECEIVER) begin
      f = (sec_q == SEC_RECEIVER) ? upcase(c) : c;
      if (ident_char(f)) begin
        r.status = ST_STORED;
        r.stored_byte = f;
        wr = 1'b1;
      end else begin
        sec_q = SEC_ERROR;
        r.status = ST_ERROR;
      end
    end else if (sec_q == SEC_COMMAND) begin
      // lowest matching index wins
      for (int i = 0; i < NUM_CODES; i++) begin
        if (!hit && cmd_codes[i] == c) begin
          hit = 1'b1;
          r.command_index = CODE_IDX_W'(i);
        end
      end
      sec_q = hit ? SEC_COLON : SEC_ERROR;
      r.status = hit ? ST_COMMAND : ST_ERROR;
    end else if (sec_q == SEC_COLON) begin
      r.status = ST_IGNORED;
    end else if (c == CH_QUOTE) begin
      quote_q = ~quote_q;
      r.status = ST_STORED;
      r.stored_byte = c;
      wr = 1'b1;
    end else begin
      f = quote_q ? c : upcase(c);
      ok = ident_char(f) || (f >= "a" && f <= "z");
      case (f)
        "+", "-", "*", "/", ".", "<", ">", "=", "%", "$", " ", ",", "(", ")": ok = 1'b1;
        default: ;
      endcase
      if (ok) begin
        r.status = ST_STORED;
        r.stored_byte = f;
        wr = 1'b1;
      end else begin
        sec_q = SEC_ERROR;
        r.status = ST_ERROR;
      end
    end
    if (wr && r.status != ST_COMPLETE) fill_q = fill_q + 9'd1;
    r.quoted = quote_q;
    return r;
  endfunction

  // input side: one transfer per accepted character
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) char_reports_due.push_back(classify_char(rx_char));
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          in_valid <= 1'b1;
          rx_char <= rx_backlog.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_report = '{status, section, stored_byte, position, command_index, quoted};
        if (char_reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d section %0d",
                   $time, status, section);
          fail_count++;
        end else begin
          want_report = char_reports_due.pop_front();
          compare_field("status", want_report.status, got_report.status);
          compare_field("section", want_report.section, got_report.section);
          compare_field("stored_byte", want_report.stored_byte, got_report.stored_byte);
          compare_field("position", want_report.position, got_report.position);
          compare_field("command_index", want_report.command_index,
                        got_report.command_index);
          compare_field("quoted", want_report.quoted, got_report.quoted);
        end
      end
      if (out_gap != 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // occasional random byte in place of the intended one
  function automatic void put_char(input logic [7:0] c);
    if ($urandom_range(0, 39) == 0) rx_backlog.push_back(8'($urandom_range(0, 255)));
    else rx_backlog.push_back(c);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_backlog.push_back(s[i]);
  endfunction

  function automatic void build_frame(input bit long_param);
    int n;
    int np;
    if ($urandom_range(0, 11) == 0) begin
      // junk line
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) rx_backlog.push_back(8'($urandom_range(0, 255)));
      rx_backlog.push_back(line_ends[$urandom_range(0, 2)]);
      return;
    end
    n = $urandom_range(1, 5);
    for (int k = 0; k < n; k++)
      put_char(($urandom_range(0, 24) == 0) ? pick(LOWER_CHARS) : pick(IDENT_CHARS));
    put_char(CH_COMMA);
    n = $urandom_range(1, 5);
    for (int k = 0; k < n; k++) put_char(pick(RECV_CHARS));
    put_char(CH_COMMA);
    put_char(($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                           : cmd_codes[$urandom_range(0, NUM_CODES - 1)]);
    if ($urandom_range(0, 7) == 0) put_char(pick(PARAM_CHARS));
    put_char(CH_COLON);
    np = ($urandom_range(0, 14) == 0) ? 7 : $urandom_range(1, 6);
    for (int p = 0; p < np; p++) begin
      if (p != 0) put_char(CH_COMMA);
      n = (long_param && p == 0) ? $urandom_range(260, 280) : $urandom_range(0, 6);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          put_char(CH_QUOTE);
          repeat ($urandom_range(0, 4)) put_char(pick(QUOTED_CHARS));
          put_char(CH_QUOTE);
        end else begin
          put_char(pick(PARAM_CHARS));
        end
      end
    end
    // line end while still inside quotes
    if ($urandom_range(0, 19) == 0) put_char(CH_QUOTE);
    put_char(line_ends[$urandom_range(0, 2)]);
  endfunction

  task automatic write_code(input int idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CODE_IDX_W'(idx);
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cmd_codes[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || in_valid || char_reports_due.size() != 0);
  endtask

  initial begin
    logic [7:0] code;
    int         frames;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      idle_on = (ph != 2 && ph != 5);
      if (ph != 0) begin
        for (int i = 0; i < NUM_CODES; i++) begin
          if (ph == 1) begin
            // extremes, with a duplicate so the lower index has to win
            code = (i < 4) ? (i[0] ? 8'hFF : 8'h00) : pick(IDENT_CHARS);
          end else begin
            case ($urandom_range(0, 3))
              0: code = 8'($urandom_range(0, 255));
              1: code = pick(IDENT_CHARS);
              2: code = pick(LOWER_CHARS);
              default: code = cmd_codes[0];
            endcase
          end
          write_code(i, code);
        end
      end
      if (ph == 0) begin
        // full frame with fold, ignored char before colon, quoted comma, six params
        push_text("A,z,Vx:Q,\"a,\",3,4,5,6\n");
        // line end in sender, colon out of place, error section, NUL
        push_text("\r:x");
        rx_backlog.push_back(CH_NUL);
      end
      frames = 0;
      while (rx_backlog.size() < 120) begin
        build_frame(ph % 3 == 1 && frames == 1);
        frames++;
      end
      wait_drained();
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && char_reports_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== command_frame_char_parser.f =====
rtl/cfcp_pkg.sv
rtl/cfcp_step.sv
rtl/command_frame_char_parser.sv
verif/command_frame_char_parser_tb.sv
